// ===== design/plle_pkg.sv =====
package plle_pkg;

    // Pool geometry
    localparam int POOL_DEPTH = 64;
    localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

    // Field widths
    localparam int CMD_W      = 3;
    localparam int SLOT_W     = 7;
    localparam int PAY_W      = 64;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 72;

    localparam logic [SLOT_W-1:0] SLOT_NIL = {SLOT_W{1'b1}};

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_HEAD = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SUCC = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

    // Datapath selectors
    typedef enum logic [1:0] {RA_IDX, RA_HEAD, RA_LRD} rd_sel_t;
    typedef enum logic {WA_USED, WA_IDX} wa_sel_t;
    typedef enum logic [1:0] {WD_CLAMP_LNK, WD_HEAD, WD_LRD, WD_USED} wd_sel_t;
    typedef enum logic [1:0] {HD_CLAMP_IDX, HD_NIL, HD_USED, HD_LRD} hd_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic                load_in;
        logic                rd_en;
        rd_sel_t             rd_sel;
        logic                pay_we;
        logic                lnk_we;
        wa_sel_t             wa_sel;
        wd_sel_t             wd_sel;
        logic                head_we;
        hd_sel_t             head_sel;
        logic                used_inc;
        logic                used_clr;
        logic                cnt_clr;
        logic                cnt_inc;
        logic                emit;
        logic [STATUS_W-1:0] emit_status;
        logic                emit_slot;
        logic                emit_pay;
        logic                emit_last;
    } ctrl_t;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             used_zero;
        logic             idx_neg;
        logic             idx_big;
        logic             head_nil;
        logic             link_nil;
        logic             cnt_last;
        logic             out_free;
    } status_t;

    // Map a slot value outside the pool to the nil link
    function automatic logic [SLOT_W-1:0] clamp_slot(input logic [SLOT_W-1:0] v);
        logic ok;
        ok = !v[SLOT_W-1] && (v < SLOT_W'(POOL_DEPTH));
        return ok ? v : SLOT_NIL;
    endfunction

    // Non-negative slot value at or beyond the pool end
    function automatic logic slot_big(input logic [SLOT_W-1:0] v);
        return !v[SLOT_W-1] && (v >= SLOT_W'(POOL_DEPTH));
    endfunction

endpackage

// ===== design/plle_ram.sv =====
module plle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds without a read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/plle_dp.sv =====
module plle_dp
    import plle_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctrl_t                ctrl,
    output status_t              st,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [CMD_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [STATUS_W-1:0]  m_tuser,
    output logic                 m_tlast
);

    // Command registers
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic [PAY_W-1:0]    pay_reg, pay_next;
    logic [SLOT_W-1:0]   lnk_reg, lnk_next;

    // List state
    logic [SLOT_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    // Result register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic [PAY_W-1:0]    out_pay_reg, out_pay_next;
    logic                out_last_reg, out_last_next;

    // Memory ports
    logic [IDX_W-1:0]    raddr;
    logic [IDX_W-1:0]    waddr;
    logic [SLOT_W-1:0]   lnk_wdata;
    logic [SLOT_W-1:0]   lnk_rdata;
    logic [PAY_W-1:0]    pay_rdata;

    // Read address
    always_comb begin
        case (ctrl.rd_sel)
            RA_IDX:  raddr = idx_reg[IDX_W-1:0];
            RA_HEAD: raddr = head_reg[IDX_W-1:0];
            RA_LRD:  raddr = lnk_rdata[IDX_W-1:0];
            default: raddr = idx_reg[IDX_W-1:0];
        endcase
    end

    // Link write address and data
    always_comb begin
        case (ctrl.wa_sel)
            WA_USED: waddr = used_reg[IDX_W-1:0];
            WA_IDX:  waddr = idx_reg[IDX_W-1:0];
            default: waddr = used_reg[IDX_W-1:0];
        endcase
        case (ctrl.wd_sel)
            WD_CLAMP_LNK: lnk_wdata = clamp_slot(lnk_reg);
            WD_HEAD:      lnk_wdata = head_reg;
            WD_LRD:       lnk_wdata = lnk_rdata;
            WD_USED:      lnk_wdata = SLOT_W'(used_reg);
            default:      lnk_wdata = SLOT_NIL;
        endcase
    end

    plle_ram #(.WIDTH(SLOT_W), .DEPTH(POOL_DEPTH)) u_links (
        .aclk  (aclk),
        .we    (ctrl.lnk_we),
        .waddr (waddr),
        .wdata (lnk_wdata),
        .re    (ctrl.rd_en),
        .raddr (raddr),
        .rdata (lnk_rdata)
    );

    plle_ram #(.WIDTH(PAY_W), .DEPTH(POOL_DEPTH)) u_payloads (
        .aclk  (aclk),
        .we    (ctrl.pay_we),
        .waddr (used_reg[IDX_W-1:0]),
        .wdata (pay_reg),
        .re    (ctrl.rd_en),
        .raddr (raddr),
        .rdata (pay_rdata)
    );

    // Capture the command on an input transfer
    always_comb begin
        cmd_next = cmd_reg;
        idx_next = idx_reg;
        pay_next = pay_reg;
        lnk_next = lnk_reg;
        if (ctrl.load_in) begin
            cmd_next = s_tuser;
            idx_next = s_tdata[SLOT_W-1:0];
            pay_next = s_tdata[SLOT_W +: PAY_W];
            lnk_next = s_tdata[SLOT_W+PAY_W +: SLOT_W];
        end
    end

    // Head, fill count and dump count
    always_comb begin
        head_next = head_reg;
        if (ctrl.head_we) begin
            case (ctrl.head_sel)
                HD_CLAMP_IDX: head_next = clamp_slot(idx_reg);
                HD_NIL:       head_next = SLOT_NIL;
                HD_USED:      head_next = SLOT_W'(used_reg);
                HD_LRD:       head_next = lnk_rdata;
                default:      head_next = SLOT_NIL;
            endcase
        end
        used_next = used_reg;
        if (ctrl.used_clr) begin
            used_next = '0;
        end else if (ctrl.used_inc) begin
            used_next = used_reg + 1'b1;
        end
        cnt_next = cnt_reg;
        if (ctrl.cnt_clr) begin
            cnt_next = '0;
        end else if (ctrl.cnt_inc) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    // Load a result, or drop it once the transfer completes
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_pay_next    = out_pay_reg;
        out_last_next   = out_last_reg;
        if (ctrl.emit) begin
            out_valid_next  = 1'b1;
            out_status_next = ctrl.emit_status;
            out_slot_next   = ctrl.emit_slot ? SLOT_W'(used_reg) : SLOT_NIL;
            out_pay_next    = ctrl.emit_pay ? pay_rdata : '0;
            out_last_next   = ctrl.emit_last;
        end else if (m_tready) begin
            out_valid_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= SLOT_NIL;
            used_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            used_reg      <= used_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
        cmd_reg        <= cmd_next;
        idx_reg        <= idx_next;
        pay_reg        <= pay_next;
        lnk_reg        <= lnk_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_pay_reg    <= out_pay_next;
        out_last_reg   <= out_last_next;
    end

    // Status towards the controller
    always_comb begin
        st.cmd       = cmd_reg;
        st.full      = (used_reg == CNT_W'(POOL_DEPTH));
        st.used_zero = (used_reg == '0);
        st.idx_neg   = idx_reg[SLOT_W-1];
        st.idx_big   = slot_big(idx_reg);
        st.head_nil  = head_reg[SLOT_W-1];
        st.link_nil  = lnk_rdata[SLOT_W-1];
        st.cnt_last  = ({1'b0, cnt_reg} + 1'b1) >= {1'b0, used_reg};
        st.out_free  = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-PAY_W-SLOT_W){1'b0}}, out_pay_reg, out_slot_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // Never overwrite a result that still waits for its transfer
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.emit |-> st.out_free)
        else $error("result register overwritten");

    // Allocation only below the pool end
    a_alloc_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.pay_we || ctrl.used_inc) |-> !st.full)
        else $error("allocation into a full pool");

    // Fill count stays within the pool
    a_used_range: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_W'(POOL_DEPTH))
        else $error("fill count beyond pool");

    // Dump never walks beyond the allocated nodes
    a_dump_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.cnt_inc |-> (cnt_reg < used_reg))
        else $error("dump beyond allocated nodes");

endmodule

// ===== design/plle_ctrl.sv =====
module plle_ctrl
    import plle_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t st,
    output ctrl_t   ctrl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_INS_LINK,
        S_INS_REF,
        S_RM_REF,
        S_RM_NODE,
        S_DUMP
    } state_t;

    state_t state_reg, state_next;

    // Sequence each command; every result waits for a free result register
    always_comb begin
        ctrl       = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ctrl.load_in = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC: begin
                case (st.cmd)
                    CMD_LOAD: begin
                        if (st.out_free) begin
                            ctrl.emit      = 1'b1;
                            ctrl.emit_last = 1'b1;
                            if (st.full) begin
                                ctrl.emit_status = ST_FULL;
                            end else begin
                                ctrl.emit_status = ST_OK;
                                ctrl.pay_we      = 1'b1;
                                ctrl.lnk_we      = 1'b1;
                                ctrl.wa_sel      = WA_USED;
                                ctrl.wd_sel      = WD_CLAMP_LNK;
                                ctrl.used_inc    = 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    CMD_SET_HEAD: begin
                        if (st.out_free) begin
                            ctrl.emit        = 1'b1;
                            ctrl.emit_last   = 1'b1;
                            ctrl.emit_status = ST_OK;
                            ctrl.head_we     = 1'b1;
                            ctrl.head_sel    = HD_CLAMP_IDX;
                            state_next       = S_IDLE;
                        end
                    end
                    CMD_INSERT: begin
                        if (st.full || st.idx_big) begin
                            if (st.out_free) begin
                                ctrl.emit        = 1'b1;
                                ctrl.emit_last   = 1'b1;
                                ctrl.emit_status = st.full ? ST_FULL : ST_NO_SUCC;
                                state_next       = S_IDLE;
                            end
                        end else if (st.idx_neg) begin
                            if (st.out_free) begin
                                ctrl.pay_we      = 1'b1;
                                ctrl.lnk_we      = 1'b1;
                                ctrl.wa_sel      = WA_USED;
                                ctrl.wd_sel      = WD_HEAD;
                                ctrl.head_we     = 1'b1;
                                ctrl.head_sel    = HD_USED;
                                ctrl.used_inc    = 1'b1;
                                ctrl.emit        = 1'b1;
                                ctrl.emit_last   = 1'b1;
                                ctrl.emit_slot   = 1'b1;
                                ctrl.emit_status = ST_OK;
                                state_next       = S_IDLE;
                            end
                        end else begin
                            ctrl.pay_we = 1'b1;
                            ctrl.rd_en  = 1'b1;
                            ctrl.rd_sel = RA_IDX;
                            state_next  = S_INS_LINK;
                        end
                    end
                    CMD_REMOVE: begin
                        if (st.idx_big || (st.idx_neg && st.head_nil)) begin
                            if (st.out_free) begin
                                ctrl.emit        = 1'b1;
                                ctrl.emit_last   = 1'b1;
                                ctrl.emit_status = st.idx_big ? ST_NO_SUCC : ST_EMPTY;
                                state_next       = S_IDLE;
                            end
                        end else if (st.idx_neg) begin
                            ctrl.rd_en  = 1'b1;
                            ctrl.rd_sel = RA_HEAD;
                            state_next  = S_RM_NODE;
                        end else begin
                            ctrl.rd_en  = 1'b1;
                            ctrl.rd_sel = RA_IDX;
                            state_next  = S_RM_REF;
                        end
                    end
                    CMD_DUMP: begin
                        if (st.head_nil || st.used_zero) begin
                            if (st.out_free) begin
                                ctrl.emit        = 1'b1;
                                ctrl.emit_last   = 1'b1;
                                ctrl.emit_status = ST_EMPTY;
                                state_next       = S_IDLE;
                            end
                        end else begin
                            ctrl.rd_en   = 1'b1;
                            ctrl.rd_sel  = RA_HEAD;
                            ctrl.cnt_clr = 1'b1;
                            state_next   = S_DUMP;
                        end
                    end
                    CMD_CLEAR: begin
                        if (st.out_free) begin
                            ctrl.emit        = 1'b1;
                            ctrl.emit_last   = 1'b1;
                            ctrl.emit_status = ST_OK;
                            ctrl.head_we     = 1'b1;
                            ctrl.head_sel    = HD_NIL;
                            ctrl.used_clr    = 1'b1;
                            state_next       = S_IDLE;
                        end
                    end
                    default: begin
                        if (st.out_free) begin
                            ctrl.emit        = 1'b1;
                            ctrl.emit_last   = 1'b1;
                            ctrl.emit_status = ST_OK;
                            state_next       = S_IDLE;
                        end
                    end
                endcase
            end
            S_INS_LINK: begin
                // new node takes over the reference node's successor
                ctrl.lnk_we = 1'b1;
                ctrl.wa_sel = WA_USED;
                ctrl.wd_sel = WD_LRD;
                state_next  = S_INS_REF;
            end
            S_INS_REF: begin
                if (st.out_free) begin
                    ctrl.lnk_we      = 1'b1;
                    ctrl.wa_sel      = WA_IDX;
                    ctrl.wd_sel      = WD_USED;
                    ctrl.used_inc    = 1'b1;
                    ctrl.emit        = 1'b1;
                    ctrl.emit_last   = 1'b1;
                    ctrl.emit_slot   = 1'b1;
                    ctrl.emit_status = ST_OK;
                    state_next       = S_IDLE;
                end
            end
            S_RM_REF: begin
                if (st.link_nil) begin
                    if (st.out_free) begin
                        ctrl.emit        = 1'b1;
                        ctrl.emit_last   = 1'b1;
                        ctrl.emit_status = ST_NO_SUCC;
                        state_next       = S_IDLE;
                    end
                end else begin
                    ctrl.rd_en  = 1'b1;
                    ctrl.rd_sel = RA_LRD;
                    state_next  = S_RM_NODE;
                end
            end
            S_RM_NODE: begin
                if (st.out_free) begin
                    if (st.idx_neg) begin
                        ctrl.head_we  = 1'b1;
                        ctrl.head_sel = HD_LRD;
                    end else begin
                        ctrl.lnk_we = 1'b1;
                        ctrl.wa_sel = WA_IDX;
                        ctrl.wd_sel = WD_LRD;
                    end
                    ctrl.emit        = 1'b1;
                    ctrl.emit_last   = 1'b1;
                    ctrl.emit_pay    = 1'b1;
                    ctrl.emit_status = ST_OK;
                    state_next       = S_IDLE;
                end
            end
            S_DUMP: begin
                if (st.out_free) begin
                    ctrl.emit        = 1'b1;
                    ctrl.emit_pay    = 1'b1;
                    ctrl.emit_status = ST_OK;
                    ctrl.emit_last   = st.link_nil || st.cnt_last;
                    ctrl.cnt_inc     = 1'b1;
                    if (st.link_nil || st.cnt_last) begin
                        state_next = S_IDLE;
                    end else begin
                        ctrl.rd_en  = 1'b1;
                        ctrl.rd_sel = RA_LRD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // A command is taken only when the engine is between commands
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load_in |-> (s_tvalid && s_tready))
        else $error("command captured outside idle");

    // The walk of a dump ends with the final result of the command
    a_dump_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DUMP && ctrl.emit && ctrl.emit_last) |=> (state_reg == S_IDLE))
        else $error("dump continued after its final result");

endmodule

// ===== design/pooled_linked_list_engine.sv =====
// Channel  Dir  tdata fields (low bit up)             tuser       tlast
// s_       in   node_index[6:0] payload_in[70:7]       cmd[2:0]    -
//               link_in[77:71], zero pad to 80 bits
// m_       out  slot[6:0] payload_out[70:7],           status[1:0] last
//               zero pad to 72 bits
//
// One command at a time, taken in S_IDLE; S_EXEC ends load, set head, clear,
// front insert and empty, full and out-of-range cases; insert after a node
// adds S_INS_LINK, S_INS_REF; remove S_RM_REF (after a node) and S_RM_NODE;
// dump S_DUMP, one node per cycle. Each link hop is one registered read.
// Synchronous active-low reset empties the list; node memories are not cleared.
// A stalled result holds in the output register and delays the next result.
module pooled_linked_list_engine
    import plle_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // node_index, payload_in, link_in
    input  logic [CMD_W-1:0]     s_tuser,   // cmd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // slot, payload_out
    output logic [STATUS_W-1:0]  m_tuser,   // status
    output logic                 m_tlast
);

    ctrl_t   ctrl;
    status_t st;

    plle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .ctrl     (ctrl)
    );

    plle_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .st       (st),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== sim/list_result_checker.sv =====
`timescale 1ns / 1ps

module list_result_checker
    import plle_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // node_index, payload_in, link_in
    input  logic [CMD_W-1:0]     s_tuser,   // cmd
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // slot, payload_out
    input  logic [STATUS_W-1:0]  m_tuser,   // status
    input  logic                 m_tlast,
    output int                   mismatch_count,
    output int                   results_outstanding
);

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [PAY_W-1:0]    payload;
        logic                last;
    } list_result_t;

    // Results still owed by the engine, oldest first
    list_result_t awaited_results[$];

    // Shadow copy of the node pool and list registers
    logic [PAY_W-1:0]         node_pay  [POOL_DEPTH];
    logic signed [SLOT_W-1:0] node_next [POOL_DEPTH];
    logic signed [SLOT_W-1:0] list_head;
    int                       nodes_taken;

    // Map anything outside the pool to the nil link
    function automatic logic signed [SLOT_W-1:0] pool_slot(
        input logic signed [SLOT_W-1:0] v
    );
        return (v >= 0 && v < POOL_DEPTH) ? v : SLOT_NIL;
    endfunction

    function automatic void await_result(
        input logic [STATUS_W-1:0] status,
        input logic [SLOT_W-1:0]   slot,
        input logic [PAY_W-1:0]    payload,
        input logic                last
    );
        list_result_t r;
        r.status  = status;
        r.slot    = slot;
        r.payload = payload;
        r.last    = last;
        awaited_results.push_back(r);
    endfunction

    // Apply one command to the shadow list and queue what it answers
    task automatic predict_command(
        input logic [CMD_W-1:0]         cmd,
        input logic signed [SLOT_W-1:0] anchor,
        input logic [PAY_W-1:0]         pay,
        input logic signed [SLOT_W-1:0] lnk
    );
        logic signed [SLOT_W-1:0] victim;
        logic signed [SLOT_W-1:0] cur;
        logic signed [SLOT_W-1:0] nxt;
        logic [SLOT_W-1:0]        fresh;
        int                       walked;
        case (cmd)
            CMD_LOAD: begin
                if (nodes_taken >= POOL_DEPTH) begin
                    await_result(ST_FULL, SLOT_NIL, '0, 1'b1);
                end else begin
                    node_pay[nodes_taken]  = pay;
                    node_next[nodes_taken] = pool_slot(lnk);
                    nodes_taken++;
                    await_result(ST_OK, SLOT_NIL, '0, 1'b1);
                end
            end
            CMD_SET_HEAD: begin
                list_head = pool_slot(anchor);
                await_result(ST_OK, SLOT_NIL, '0, 1'b1);
            end
            CMD_INSERT: begin
                if (nodes_taken >= POOL_DEPTH) begin
                    await_result(ST_FULL, SLOT_NIL, '0, 1'b1);
                end else if (anchor >= POOL_DEPTH) begin
                    await_result(ST_NO_SUCC, SLOT_NIL, '0, 1'b1);
                end else begin
                    fresh = SLOT_W'(nodes_taken);
                    node_pay[nodes_taken] = pay;
                    if (anchor < 0) begin
                        node_next[nodes_taken] = list_head;
                        list_head = fresh;
                    end else begin
                        node_next[nodes_taken] = node_next[anchor[IDX_W-1:0]];
                        node_next[anchor[IDX_W-1:0]] = fresh;
                    end
                    nodes_taken++;
                    await_result(ST_OK, fresh, '0, 1'b1);
                end
            end
            CMD_REMOVE: begin
                if (anchor >= POOL_DEPTH) begin
                    await_result(ST_NO_SUCC, SLOT_NIL, '0, 1'b1);
                end else if (anchor < 0) begin
                    victim = list_head;
                    if (victim < 0) begin
                        await_result(ST_EMPTY, SLOT_NIL, '0, 1'b1);
                    end else begin
                        list_head = node_next[victim[IDX_W-1:0]];
                        await_result(ST_OK, SLOT_NIL, node_pay[victim[IDX_W-1:0]], 1'b1);
                    end
                end else begin
                    victim = node_next[anchor[IDX_W-1:0]];
                    if (victim < 0) begin
                        await_result(ST_NO_SUCC, SLOT_NIL, '0, 1'b1);
                    end else begin
                        node_next[anchor[IDX_W-1:0]] = node_next[victim[IDX_W-1:0]];
                        await_result(ST_OK, SLOT_NIL, node_pay[victim[IDX_W-1:0]], 1'b1);
                    end
                end
            end
            CMD_DUMP: begin
                // Walk from the head, capped by the number of slots handed out
                walked = 0;
                cur    = list_head;
                if (cur < 0 || nodes_taken == 0) begin
                    await_result(ST_EMPTY, SLOT_NIL, '0, 1'b1);
                end else begin
                    while (cur >= 0 && walked < nodes_taken) begin
                        nxt = node_next[cur[IDX_W-1:0]];
                        walked++;
                        await_result(ST_OK, SLOT_NIL, node_pay[cur[IDX_W-1:0]],
                                     !(nxt >= 0 && walked < nodes_taken));
                        cur = nxt;
                    end
                end
            end
            CMD_CLEAR: begin
                list_head   = SLOT_NIL;
                nodes_taken = 0;
                await_result(ST_OK, SLOT_NIL, '0, 1'b1);
            end
            default: begin
                await_result(ST_OK, SLOT_NIL, '0, 1'b1);
            end
        endcase
    endtask

    // Compare each result transfer, then predict from each command transfer
    always @(posedge aclk) begin : watch
        list_result_t want;
        if (!aresetn) begin
            list_head   = SLOT_NIL;
            nodes_taken = 0;
            for (int i = 0; i < POOL_DEPTH; i++) begin
                node_pay[i]  = '0;
                node_next[i] = '0;
            end
            awaited_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result: status %0d slot 0x%02h payload_out 0x%016h last %0d",
                           m_tuser, m_tdata[SLOT_W-1:0], m_tdata[SLOT_W +: PAY_W], m_tlast);
                    mismatch_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_tuser);
                        mismatch_count++;
                    end
                    if (m_tdata[SLOT_W-1:0] !== want.slot) begin
                        $error("slot: expected 0x%02h, actual 0x%02h",
                               want.slot, m_tdata[SLOT_W-1:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[SLOT_W +: PAY_W] !== want.payload) begin
                        $error("payload_out: expected 0x%016h, actual 0x%016h",
                               want.payload, m_tdata[SLOT_W +: PAY_W]);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, m_tlast);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_command(s_tuser, s_tdata[SLOT_W-1:0], s_tdata[SLOT_W +: PAY_W],
                                s_tdata[SLOT_W+PAY_W +: SLOT_W]);
            end
        end
        results_outstanding = awaited_results.size();
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import plle_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 500;
    localparam int HOLD_AFTER    = 150;
    localparam int HOLD_CYCLES   = 500;
    localparam int DRAIN_CYCLES  = 50;
    localparam int PAD_W         = S_TDATA_W - 2 * SLOT_W - PAY_W;

    // Command codes the engine leaves unused
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    // Front-of-list reference, and the lowest value past the pool end
    localparam logic [SLOT_W-1:0] REF_FRONT = SLOT_NIL;
    localparam logic [SLOT_W-1:0] REF_LOWEST = 7'h40;

    typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE} rx_mode_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // node_index, payload_in, link_in
    logic [CMD_W-1:0]     s_tuser;   // cmd
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // slot, payload_out
    logic [STATUS_W-1:0]  m_tuser;   // status
    logic                 m_tlast;

    int mismatch_count;
    int results_outstanding;
    int cycle_count;
    int accepted_items;
    int burst_left;

    // Which pool slots hold written data, and how many are handed out
    int unsigned shadow_used;
    bit          slot_written [POOL_DEPTH];
    int          written_slots[$];

    pooled_linked_list_engine DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    list_result_checker u_result_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .s_tuser             (s_tuser),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .m_tuser             (m_tuser),
        .m_tlast             (m_tlast),
        .mismatch_count      (mismatch_count),
        .results_outstanding (results_outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Abort a run that hangs
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    function automatic void mark_written(input int unsigned s);
        if (!slot_written[s]) begin
            slot_written[s] = 1'b1;
            written_slots.push_back(s);
        end
    endfunction

    // Reference for insert, remove or set head: front, or a slot with data
    function automatic logic [SLOT_W-1:0] pick_anchor();
        if (written_slots.size() == 0 || $urandom_range(0, 4) == 0)
            return SLOT_W'($urandom_range(64, 127));
        return SLOT_W'(written_slots[$urandom_range(0, written_slots.size() - 1)]);
    endfunction

    // Successor for a load: none, the slot being loaded, or a slot with data
    function automatic logic [SLOT_W-1:0] pick_link();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 3 || written_slots.size() == 0)
            return SLOT_W'($urandom_range(64, 127));
        if (r == 3)
            return SLOT_W'(shadow_used);
        return SLOT_W'(written_slots[$urandom_range(0, written_slots.size() - 1)]);
    endfunction

    function automatic logic [PAY_W-1:0] rand_payload();
        return {$urandom, $urandom};
    endfunction

    // Offer one command, hold it until the transfer, then maybe pause
    task automatic send_cmd(
        input logic [CMD_W-1:0]  cmd,
        input logic [SLOT_W-1:0] anchor,
        input logic [PAY_W-1:0]  pay,
        input logic [SLOT_W-1:0] lnk
    );
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{PAD_W{1'b0}}, lnk, pay, anchor};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        accepted_items++;
        case (cmd)
            CMD_LOAD, CMD_INSERT: begin
                if (shadow_used < POOL_DEPTH) begin
                    mark_written(shadow_used);
                    shadow_used++;
                end
            end
            CMD_CLEAR: shadow_used = 0;
            default: ;
        endcase
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 20);
        end
    endtask

    // One random command; fill phases lean on allocation to reach a full pool
    task automatic send_random(input bit fill);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (fill) begin
            if (r < 45)      send_cmd(CMD_LOAD, pick_anchor(), rand_payload(), pick_link());
            else if (r < 85) send_cmd(CMD_INSERT, pick_anchor(), rand_payload(), pick_link());
            else if (r < 92) send_cmd(CMD_DUMP, pick_anchor(), rand_payload(), pick_link());
            else             send_cmd(CMD_REMOVE, pick_anchor(), rand_payload(), pick_link());
        end else begin
            if (r < 20)      send_cmd(CMD_LOAD, pick_anchor(), rand_payload(), pick_link());
            else if (r < 45) send_cmd(CMD_INSERT, pick_anchor(), rand_payload(), pick_link());
            else if (r < 70) send_cmd(CMD_REMOVE, pick_anchor(), rand_payload(), pick_link());
            else if (r < 82) send_cmd(CMD_DUMP, pick_anchor(), rand_payload(), pick_link());
            else if (r < 90) send_cmd(CMD_SET_HEAD, pick_anchor(), rand_payload(), pick_link());
            else if (r < 93) send_cmd(CMD_CLEAR, pick_anchor(), rand_payload(), pick_link());
            else if (r < 96) send_cmd(CMD_SPARE_LO, pick_anchor(), rand_payload(), pick_link());
            else             send_cmd(CMD_SPARE_HI, pick_anchor(), rand_payload(), pick_link());
        end
    endtask

    // Receiver: stall patterns with bounded low runs, plus one long hold-off
    initial begin : receiver
        rx_mode_t mode;
        int       seg_len;
        int       low_run;
        bit       hold_done;
        bit       ready_now;
        low_run   = 0;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            mode    = rx_mode_t'($urandom_range(0, 2));
            seg_len = $urandom_range(30, 300);
            if (!hold_done && accepted_items >= HOLD_AFTER) begin
                @(posedge aclk);
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end
            repeat (seg_len) begin
                @(posedge aclk);
                case (mode)
                    RX_OPEN: ready_now = 1'b1;
                    RX_HALF: ready_now = ($urandom_range(0, 1) == 1) || low_run >= 3;
                    default: ready_now = ($urandom_range(0, 3) == 0) || low_run >= 3;
                endcase
                low_run = ready_now ? 0 : low_run + 1;
                m_tready <= ready_now;
            end
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        bit fill;
        int ep_len;
        int random_sent;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = CMD_LOAD;
        aresetn        = 1'b0;
        accepted_items = 0;
        shadow_used    = 0;
        random_sent    = 0;
        burst_left     = $urandom_range(1, 20);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty list, unused codes, then build and pick apart a small list
        send_cmd(CMD_DUMP, REF_FRONT, '0, REF_FRONT);
        send_cmd(CMD_REMOVE, REF_FRONT, '0, REF_FRONT);
        send_cmd(CMD_SPARE_LO, 7'h2A, '1, 7'h15);
        send_cmd(CMD_SPARE_HI, 7'h15, '0, 7'h2A);
        send_cmd(CMD_LOAD, REF_FRONT, '0, REF_LOWEST);
        send_cmd(CMD_LOAD, REF_FRONT, '1, 7'h00);
        send_cmd(CMD_SET_HEAD, 7'h01, '0, REF_FRONT);
        send_cmd(CMD_DUMP, REF_FRONT, '0, REF_FRONT);
        send_cmd(CMD_INSERT, REF_FRONT, 64'h0123_4567_89AB_CDEF, REF_FRONT);
        send_cmd(CMD_INSERT, 7'h00, 64'hFEDC_BA98_7654_3210, REF_FRONT);
        // Tail node has no successor
        send_cmd(CMD_REMOVE, 7'h03, '0, REF_FRONT);
        send_cmd(CMD_REMOVE, 7'h01, '0, REF_FRONT);
        send_cmd(CMD_REMOVE, REF_FRONT, '0, REF_FRONT);
        send_cmd(CMD_DUMP, REF_FRONT, '0, REF_FRONT);
        // Head out of the pool reads as nil
        send_cmd(CMD_SET_HEAD, REF_LOWEST, '0, REF_FRONT);
        send_cmd(CMD_DUMP, REF_FRONT, '0, REF_FRONT);
        // Self loop: dump stops after the slots handed out
        send_cmd(CMD_LOAD, REF_FRONT, 64'hA5A5_5A5A_C3C3_3C3C, 7'h04);
        send_cmd(CMD_SET_HEAD, 7'h04, '0, REF_FRONT);
        send_cmd(CMD_DUMP, REF_FRONT, '0, REF_FRONT);
        send_cmd(CMD_INSERT, 7'h55, 64'h8000_0000_0000_0001, REF_FRONT);
        send_cmd(CMD_DUMP, REF_FRONT, '0, REF_FRONT);
        send_cmd(CMD_CLEAR, REF_FRONT, '0, REF_FRONT);
        send_cmd(CMD_DUMP, REF_FRONT, '0, REF_FRONT);
        send_cmd(CMD_REMOVE, REF_FRONT, '0, REF_FRONT);

        // Random episodes, most starting from a cleared list
        while (random_sent < RANDOM_ITEMS) begin
            fill = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0) begin
                send_cmd(CMD_CLEAR, pick_anchor(), rand_payload(), pick_link());
                random_sent++;
            end
            ep_len = fill ? $urandom_range(70, 90) : $urandom_range(10, 40);
            repeat (ep_len) begin
                send_random(fill);
                random_sent++;
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then allow for stray results
        do @(negedge aclk); while (results_outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
